/* sv/hcbd_pkg.sv */
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_BITS_DEF = 64;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_SIZE       = 4'd1,
        PH_EXTENSION  = 4'd2,
        PH_SIZE_CR    = 4'd3,
        PH_DATA       = 4'd4,
        PH_AFTER_DATA = 4'd5,
        PH_AFTER_CR   = 4'd6,
        PH_DONE       = 4'd7,
        PH_BAD        = 4'd8,
        PH_OVERFLOW   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_DONE     = 2'd1,
        ST_INVALID  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        status_t    status;
    } result_t;

    function automatic logic hex_ok(input logic [7:0] b);
        logic [7:0] up;
        up = b & CASE_MASK;
        return ((b >= CH_ZERO) && (b <= CH_NINE)) || ((up >= CH_UP_A) && (up <= CH_UP_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] up;
        logic [7:0] v;
        up = b & CASE_MASK;
        if ((b >= CH_ZERO) && (b <= CH_NINE))
        begin
            v = b - CH_ZERO;
        end
        else
        begin
            v = up - CH_UP_A + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

/* sv/hcbd_in_reg.sv */
`default_nettype none

module hcbd_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       advance,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] byte_reg;

    // the held word leaves in the same cycle a new one may enter
    assign s_tready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tready)
        begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign held_valid = vld_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

/* sv/hcbd_core.sv */
`default_nettype none

module hcbd_core #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    output hcbd_pkg::result_t result
);

    import hcbd_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [SIZE_BITS-1:0] len_reg;
    logic [SIZE_BITS-1:0] len_next;
    logic [SIZE_BITS-1:0] cnt_reg;
    logic [SIZE_BITS-1:0] cnt_next;
    logic [SIZE_BITS-1:0] cnt_inc;
    logic                 is_hex;
    logic [3:0]           digit;
    logic                 top_busy;

    assign is_hex   = hex_ok(data_byte);
    assign digit    = hex_val(data_byte);
    assign cnt_inc  = cnt_reg + SIZE_BITS'(1);
    assign top_busy = (len_reg[SIZE_BITS-1 -: 4] != 4'd0);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_LINE_START:
            begin
                if (!is_hex)
                begin
                    phase_next = PH_BAD;
                end
                else
                begin
                    len_next   = SIZE_BITS'(digit);
                    cnt_next   = '0;
                    phase_next = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (is_hex)
                begin
                    if (top_busy)
                    begin
                        phase_next = PH_OVERFLOW;
                    end
                    else
                    begin
                        len_next = {len_reg[SIZE_BITS-5:0], digit};
                    end
                end
                else if (data_byte == CH_SPACE || data_byte == CH_TAB || data_byte == CH_SEMI)
                begin
                    phase_next = PH_EXTENSION;
                end
                else if (data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_CR;
                end
                else if (data_byte == CH_LF)
                begin
                    phase_next = (len_reg == '0) ? PH_DONE : PH_DATA;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_EXTENSION:
            begin
                if (data_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_CR;
                end
                else if (data_byte == CH_LF)
                begin
                    phase_next = (len_reg == '0) ? PH_DONE : PH_DATA;
                end
            end
            PH_SIZE_CR:
            begin
                if (data_byte == CH_LF)
                begin
                    phase_next = (len_reg == '0) ? PH_DONE : PH_DATA;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_DATA:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == len_reg)
                begin
                    phase_next = PH_AFTER_DATA;
                end
            end
            PH_AFTER_DATA:
            begin
                if (data_byte == CH_CR)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else if (data_byte == CH_LF)
                begin
                    phase_next = PH_LINE_START;
                end
                else
                begin
                    phase_next = PH_BAD;
                end
            end
            PH_AFTER_CR:
            begin
                phase_next = (data_byte == CH_LF) ? PH_LINE_START : PH_BAD;
            end
            PH_DONE, PH_BAD, PH_OVERFLOW:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_BAD;
            end
        endcase
    end

    // status reflects the phase after this word
    always_comb
    begin
        result.payload_valid = (phase_reg == PH_DATA);
        result.payload_byte  = result.payload_valid ? data_byte : 8'd0;
        unique case (phase_next)
            PH_DONE:     result.status = ST_DONE;
            PH_BAD:      result.status = ST_INVALID;
            PH_OVERFLOW: result.status = ST_OVERFLOW;
            default:     result.status = ST_RUNNING;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/hcbd_out_reg.sv */
`default_nettype none

module hcbd_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         held_valid,
    input  hcbd_pkg::result_t result,
    output logic              advance,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser
);

    import hcbd_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign advance = held_valid && (!vld_reg || m_tready);

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.payload_byte};
    assign m_tuser  = res_reg.payload_valid;

endmodule

`default_nettype wire

/* sv/http_chunked_body_decoder_top.sv */
`default_nettype none

// channel   dir  handshake            tdata                              tuser
// s_*       in   s_tvalid/s_tready    [7:0] data_byte                    -
// m_*       out  m_tvalid/m_tready    [7:0] payload_byte, [9:8] status   [0] payload_valid
//
// one word per cycle sustained while the output is not stalled; an accepted input
// word passes through the input register, then the phase/size update and result register
// the size update is a nibble shift and the payload count one increment and compare
// reset clears the phase, size and count and empties both registers
// a stalled output holds its word while the input register still takes one more

module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] payload_byte, [9:8] status
    output logic             m_tuser    // [0] payload_valid
);

    import hcbd_pkg::*;

    logic       advance;
    logic       held_valid;
    logic [7:0] held_byte;
    result_t    result;

    hcbd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (held_byte),
        .result    (result)
    );

    hcbd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .result     (result),
        .advance    (advance),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

/* sim/tb_http_chunked_body_decoder_top.sv */
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_top;

    import hcbd_pkg::*;

    localparam int          LEN_W       = SIZE_BITS_DEF;
    localparam logic [7:0]  CH_LOW_A    = 8'h61;
    localparam logic [7:0]  CH_LOW_F    = 8'h66;
    localparam int          IDLE_PCT    = 17;
    localparam int          BODY_BYTES  = 800;
    localparam int          HOLD_CYCLES = 250;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 10;

    typedef enum int {
        END_DONE,
        END_OVERFLOW,
        END_LINE_START,
        END_AFTER_SIZE,
        END_SIZE_CR,
        END_AFTER_DATA,
        END_DATA_CR
    } ending_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    logic [7:0]  body_q[$];
    result_t     decoded_q[$];

    // decoder state as the block should see it
    phase_t          dec_phase = PH_LINE_START;
    logic [LEN_W-1:0] dec_len  = '0;
    logic [LEN_W-1:0] dec_count = '0;

    int unsigned sent_count   = 0;
    int unsigned got_count    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left    = 0;
    bit          held         = 1'b0;
    int          mismatches   = 0;

    http_chunked_body_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int nibble_of(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            return int'(b - CH_ZERO);
        end
        if (b >= CH_UP_A && b <= CH_UP_F)
        begin
            return int'(b - CH_UP_A) + 10;
        end
        if (b >= CH_LOW_A && b <= CH_LOW_F)
        begin
            return int'(b - CH_LOW_A) + 10;
        end
        return -1;
    endfunction

    // advances the expected decoder by one body byte
    function automatic result_t decode_byte(input logic [7:0] b);
        result_t r;
        int      d;
        r.payload_byte  = 8'h00;
        r.payload_valid = 1'b0;
        d = nibble_of(b);
        case (dec_phase)
            PH_LINE_START, PH_SIZE:
            begin
                if (dec_phase == PH_LINE_START)
                begin
                    if (d < 0)
                    begin
                        dec_phase = PH_BAD;
                    end
                    else
                    begin
                        dec_len   = '0;
                        dec_count = '0;
                        dec_phase = PH_SIZE;
                    end
                end
                if (dec_phase == PH_SIZE)
                begin
                    if (d >= 0)
                    begin
                        if (dec_len[LEN_W-1 -: 4] != 4'h0)
                        begin
                            dec_phase = PH_OVERFLOW;
                        end
                        else
                        begin
                            dec_len = {dec_len[LEN_W-5:0], d[3:0]};
                        end
                    end
                    else if (b == CH_SPACE || b == CH_TAB || b == CH_SEMI)
                    begin
                        dec_phase = PH_EXTENSION;
                    end
                    else if (b == CH_CR)
                    begin
                        dec_phase = PH_SIZE_CR;
                    end
                    else if (b == CH_LF)
                    begin
                        dec_phase = (dec_len == 0) ? PH_DONE : PH_DATA;
                    end
                    else
                    begin
                        dec_phase = PH_BAD;
                    end
                end
            end
            PH_EXTENSION:
            begin
                if (b == CH_CR)
                begin
                    dec_phase = PH_SIZE_CR;
                end
                else if (b == CH_LF)
                begin
                    dec_phase = (dec_len == 0) ? PH_DONE : PH_DATA;
                end
            end
            PH_SIZE_CR:
            begin
                if (b == CH_LF)
                begin
                    dec_phase = (dec_len == 0) ? PH_DONE : PH_DATA;
                end
                else
                begin
                    dec_phase = PH_BAD;
                end
            end
            PH_DATA:
            begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                dec_count = dec_count + 1'b1;
                if (dec_count == dec_len)
                begin
                    dec_phase = PH_AFTER_DATA;
                end
            end
            PH_AFTER_DATA:
            begin
                if (b == CH_CR)
                begin
                    dec_phase = PH_AFTER_CR;
                end
                else if (b == CH_LF)
                begin
                    dec_phase = PH_LINE_START;
                end
                else
                begin
                    dec_phase = PH_BAD;
                end
            end
            PH_AFTER_CR:
            begin
                dec_phase = (b == CH_LF) ? PH_LINE_START : PH_BAD;
            end
            PH_DONE, PH_BAD, PH_OVERFLOW:
            begin
            end
            default:
            begin
                dec_phase = PH_BAD;
            end
        endcase
        case (dec_phase)
            PH_DONE:     r.status = ST_DONE;
            PH_BAD:      r.status = ST_INVALID;
            PH_OVERFLOW: r.status = ST_OVERFLOW;
            default:     r.status = ST_RUNNING;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + nib;
        end
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + nib - 4'd10;
    endfunction

    task automatic put_eol();
        if ($urandom_range(0, 1))
        begin
            body_q.push_back(CH_CR);
        end
        body_q.push_back(CH_LF);
    endtask

    task automatic put_size_line(input logic [LEN_W-1:0] len);
        int         nd;
        int         pad;
        logic [7:0] c;
        nd  = 1;
        pad = 0;
        while (nd < LEN_W / 4 && (len >> (4 * nd)) != 0)
        begin
            nd++;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            pad = int'($urandom_range(0, LEN_W / 4 - nd));
        end
        repeat (pad) body_q.push_back(CH_ZERO);
        for (int i = nd - 1; i >= 0; i--)
        begin
            body_q.push_back(hex_char(len[4 * i +: 4]));
        end
        // extension text may hold anything but a line end
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       body_q.push_back(CH_SPACE);
                1:       body_q.push_back(CH_TAB);
                default: body_q.push_back(CH_SEMI);
            endcase
            repeat ($urandom_range(0, 6))
            begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                body_q.push_back(c);
            end
        end
        put_eol();
    endtask

    task automatic put_chunk(input logic [LEN_W-1:0] len);
        put_size_line(len);
        repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
        put_eol();
    endtask

    // driver: one word offered at a time, prediction taken at the handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            sent_count <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                decoded_q.push_back(decode_byte(s_tdata));
                sent_count <= sent_count + 1;
            end
            if (body_q.size() != 0 &&
                ((sent_count >= 500 && sent_count < 700) ||
                 $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= body_q.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result word and drives the output stall
    always @(posedge clk or negedge rst_n)
    begin
        result_t    want;
        logic [7:0] got_byte;
        logic       got_valid;
        logic [1:0] got_status;
        logic       next_ready;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            got_count <= 0;
            hold_left <= 0;
            held      <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_count  <= got_count + 1;
                got_byte   = m_tdata[7:0];
                got_valid  = m_tuser;
                got_status = m_tdata[9:8];
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected word %04h user %0d", $time, m_tdata, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got_byte !== want.payload_byte)
                    begin
                        $display("%0t: payload_byte expected %02h got %02h",
                                 $time, want.payload_byte, got_byte);
                        mismatches++;
                    end
                    if (got_valid !== want.payload_valid)
                    begin
                        $display("%0t: payload_valid expected %0d got %0d",
                                 $time, want.payload_valid, got_valid);
                        mismatches++;
                    end
                    if (got_status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got_status);
                        mismatches++;
                    end
                end
            end
            // one long hold so the input side backs up
            if (!held && got_count == 300)
            begin
                held       <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                next_ready = 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left  <= hold_left - 1;
                next_ready = 1'b0;
            end
            else if (got_count >= 500 && got_count < 700)
            begin
                next_ready = 1'b1;
            end
            else
            begin
                next_ready = ($urandom_range(0, 99) >= IDLE_PCT);
            end
            m_tready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  c;
        ending_t     ending;
        int unsigned total;
        // extensions of each kind, crlf and bare lf, leading zeros,
        // payload holding 00, ff and line-end bytes
        body_q = '{"2", CH_SEMI, 8'hFF, CH_CR, CH_LF, 8'h00, 8'hFF, CH_CR, CH_LF,
                   "0", "0", "0", "1", CH_TAB, CH_LF, CH_CR, CH_LF,
                   "1", CH_SPACE, CH_SEMI, CH_CR, CH_LF, CH_LF, CH_CR, CH_LF};
        while (body_q.size() < BODY_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                put_chunk(LEN_W'($urandom_range(25, 80)));
            end
            else
            begin
                put_chunk(LEN_W'($urandom_range(1, 24)));
            end
        end
        // the body ends once, either cleanly or in one of the error cases
        ending = ending_t'($urandom_range(0, 6));
        case (ending)
            END_DONE:
            begin
                put_size_line('0);
            end
            END_OVERFLOW:
            begin
                body_q.push_back(hex_char(4'($urandom_range(1, 15))));
                repeat (LEN_W / 4) body_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
            END_LINE_START:
            begin
                do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
                body_q.push_back(c);
            end
            END_AFTER_SIZE:
            begin
                body_q.push_back(hex_char(4'($urandom_range(0, 15))));
                do c = 8'($urandom_range(0, 255));
                while (nibble_of(c) >= 0 || c == CH_SPACE || c == CH_TAB ||
                       c == CH_SEMI || c == CH_CR || c == CH_LF);
                body_q.push_back(c);
            end
            END_SIZE_CR:
            begin
                body_q.push_back(hex_char(4'($urandom_range(1, 15))));
                body_q.push_back(CH_CR);
                do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                body_q.push_back(c);
            end
            END_AFTER_DATA:
            begin
                put_size_line(LEN_W'(1));
                body_q.push_back(8'($urandom_range(0, 255)));
                do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
                body_q.push_back(c);
            end
            default:
            begin
                put_size_line(LEN_W'(1));
                body_q.push_back(8'($urandom_range(0, 255)));
                body_q.push_back(CH_CR);
                do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                body_q.push_back(c);
            end
        endcase
        // trailer or junk after the end must leave the final status in place
        repeat (30) body_q.push_back(8'($urandom_range(0, 255)));
        total = body_q.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (got_count < total)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* http_chunked_body_decoder_top.f */
sv/hcbd_pkg.sv
sv/hcbd_in_reg.sv
sv/hcbd_core.sv
sv/hcbd_out_reg.sv
sv/http_chunked_body_decoder_top.sv
sim/tb_http_chunked_body_decoder_top.sv
